### src/websocket_frame_deframer_unmask_unit_defines.svh
// ----------------------------------------------------------------------------
// WebSocket deframer assertion macros
// Shared concurrent assertion forms for the deframer checker.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNMASK_UNIT_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNMASK_UNIT_DEFINES_SVH

// same-cycle implication
`define WSDF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WSDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/wsdf_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Types and constants shared by the deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wsdf_pkg;

  localparam int LEN_W = 63;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SECOND,
    PH_EXTLEN,
    PH_KEY,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TEXT,
    KIND_BINARY,
    KIND_CLOSE,
    KIND_ERROR
  } kind_t;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [2:0] EXT16_LEFT = 3'd1;
  localparam logic [2:0] EXT64_LEFT = 3'd7;

  localparam logic [1:0] KEY_LAST = 2'd3;

  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7e;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             is_payload;
    kind_t            frame_kind;
    logic             header_done;
    logic [LEN_W-1:0] payload_length;
    logic             frame_end;
    logic             bad_text;
    logic             error_flag;
  } wsdf_result_t;

endpackage

`default_nettype wire

### src/wsdf_core.sv
// ----------------------------------------------------------------------------
// WebSocket deframer core
// Frame state and per-byte decode: header parse, length, key, unmasking.
// ----------------------------------------------------------------------------
`default_nettype none

module wsdf_core
  import wsdf_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         step,
  input  wire logic [7:0]   in_byte,
  input  wire logic         text_check_enable,
  output wsdf_result_t      result
);

  phase_t             phase, phase_next;
  kind_t              kind_reg, kind_reg_next;
  logic               masked_reg, masked_reg_next;
  logic [2:0]         ext_left, ext_left_next;
  logic [31:0]        mask_key, mask_key_next;
  logic [1:0]         mask_index, mask_index_next;
  logic [LEN_W-1:0]   length_acc, length_acc_next;
  logic [LEN_W-1:0]   payload_left, payload_left_next;
  logic               halted, halted_next;

  logic [6:0]         len7;
  logic               payload_last;
  logic [7:0]         key_byte;

  assign len7         = in_byte[6:0];
  assign payload_last = (payload_left <= LEN_W'(1));

  always_comb begin
    case (mask_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    logic             hdr_len_done;
    logic             hdr_masked;
    logic [LEN_W-1:0] hdr_len;
    phase_next        = phase;
    kind_reg_next     = kind_reg;
    masked_reg_next   = masked_reg;
    ext_left_next     = ext_left;
    mask_key_next     = mask_key;
    mask_index_next   = mask_index;
    length_acc_next   = length_acc;
    payload_left_next = payload_left;
    halted_next       = halted;
    hdr_len_done      = 1'b0;
    hdr_masked        = masked_reg;
    hdr_len           = length_acc;
    if (!halted) begin
      case (phase)
        PH_FIRST: begin
          length_acc_next   = '0;
          payload_left_next = '0;
          phase_next        = PH_SECOND;
          case (in_byte[3:0])
            OP_TEXT:   kind_reg_next = KIND_TEXT;
            OP_BINARY: kind_reg_next = KIND_BINARY;
            OP_CLOSE:  kind_reg_next = KIND_CLOSE;
            default: begin
              kind_reg_next = KIND_ERROR;
              halted_next   = 1'b1;
              phase_next    = PH_FIRST;
            end
          endcase
        end
        PH_SECOND: begin
          masked_reg_next = in_byte[7];
          hdr_masked      = in_byte[7];
          length_acc_next = '0;
          if (len7 == LEN7_EXT16) begin
            ext_left_next = EXT16_LEFT;
            phase_next    = PH_EXTLEN;
          end else if (len7 == LEN7_EXT64) begin
            ext_left_next = EXT64_LEFT;
            phase_next    = PH_EXTLEN;
          end else begin
            length_acc_next = {{(LEN_W-7){1'b0}}, len7};
            hdr_len         = {{(LEN_W-7){1'b0}}, len7};
            hdr_len_done    = 1'b1;
          end
        end
        PH_EXTLEN: begin
          length_acc_next = {length_acc[LEN_W-9:0], in_byte};
          hdr_len         = {length_acc[LEN_W-9:0], in_byte};
          if (ext_left == 3'd0) begin
            hdr_len_done = 1'b1;
          end else begin
            ext_left_next = ext_left - 3'd1;
          end
        end
        PH_KEY: begin
          mask_key_next = {mask_key[23:0], in_byte};
          if (mask_index == KEY_LAST) begin
            mask_index_next = 2'd0;
            if (length_acc == '0) begin
              phase_next = PH_FIRST;
            end else begin
              payload_left_next = length_acc;
              phase_next        = PH_PAYLOAD;
            end
          end else begin
            mask_index_next = mask_index + 2'd1;
          end
        end
        PH_PAYLOAD: begin
          if (masked_reg) begin
            mask_index_next = mask_index + 2'd1;
          end
          if (payload_last) begin
            payload_left_next = '0;
            phase_next        = PH_FIRST;
          end else begin
            payload_left_next = payload_left - LEN_W'(1);
          end
        end
        default: phase_next = PH_FIRST;
      endcase
      if (hdr_len_done) begin
        if (hdr_masked) begin
          phase_next      = PH_KEY;
          mask_index_next = 2'd0;
          mask_key_next   = '0;
        end else if (hdr_len == '0) begin
          phase_next = PH_FIRST;
        end else begin
          payload_left_next = hdr_len;
          phase_next        = PH_PAYLOAD;
        end
      end
    end
  end

  always_comb begin
    logic [7:0] ob;
    logic       hdr;
    ob  = in_byte;
    hdr = 1'b0;
    result = '0;
    if (halted) begin
      result.out_byte   = in_byte;
      result.frame_kind = KIND_ERROR;
      result.error_flag = 1'b1;
    end else begin
      case (phase)
        PH_SECOND: hdr = (len7 != LEN7_EXT16) && (len7 != LEN7_EXT64) && !in_byte[7];
        PH_EXTLEN: hdr = (ext_left == 3'd0) && !masked_reg;
        PH_KEY:    hdr = (mask_index == KEY_LAST);
        default:   hdr = 1'b0;
      endcase
      if (phase == PH_PAYLOAD && masked_reg) begin
        ob = in_byte ^ key_byte;
      end
      result.out_byte       = ob;
      result.is_payload     = (phase == PH_PAYLOAD);
      result.frame_kind     = kind_reg_next;
      result.header_done    = hdr;
      result.payload_length = length_acc_next;
      result.frame_end      = (hdr && (length_acc_next == '0)) ||
                              ((phase == PH_PAYLOAD) && payload_last);
      result.bad_text       = (phase == PH_PAYLOAD) && masked_reg &&
                              (kind_reg == KIND_TEXT) && text_check_enable &&
                              !payload_last && ((ob < PRINT_LO) || (ob > PRINT_HI));
      result.error_flag     = halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_FIRST;
      kind_reg     <= KIND_TEXT;
      masked_reg   <= 1'b0;
      ext_left     <= '0;
      mask_key     <= '0;
      mask_index   <= '0;
      length_acc   <= '0;
      payload_left <= '0;
      halted       <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      kind_reg     <= kind_reg_next;
      masked_reg   <= masked_reg_next;
      ext_left     <= ext_left_next;
      mask_key     <= mask_key_next;
      mask_index   <= mask_index_next;
      length_acc   <= length_acc_next;
      payload_left <= payload_left_next;
      halted       <= halted_next;
    end
  end

endmodule

`default_nettype wire

### src/websocket_frame_deframer_unmask_unit.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer with unmasking
// Byte-stream frame parser: opcode, length, masking key, unmasked payload.
// ----------------------------------------------------------------------------
// Takes one stream byte per beat and returns one result beat per byte. The
// block sustains one byte per clock while out_stall is low: each accepted
// byte sits in an input register, is decoded against the frame state and
// lands in the output register, and the input register takes one more byte
// while a result waits. The length counter is a 63-bit compare and
// decrement. An unknown opcode halts the parser; every later byte is
// reported as an error until reset. The user must write the
// text_check_enable register through the cfg port only while idle; the
// block itself does not enforce it.
`default_nettype none

module websocket_frame_deframer_unmask_unit
  import wsdf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_byte,
  output logic                   is_payload,
  output logic [1:0]             frame_kind,
  output logic                   header_done,
  output logic [LEN_W-1:0]       payload_length,
  output logic                   frame_end,
  output logic                   bad_text,
  output logic                   error_flag,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_data
);

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         text_check_enable;
  logic         out_free;
  logic         advance;
  logic         in_accept;
  wsdf_result_t core_result;
  wsdf_result_t out_reg;

  assign out_free  = !out_valid || !out_stall;
  assign advance   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  wsdf_core u_core (
    .clk               (clk),
    .rst               (rst),
    .step              (advance),
    .in_byte           (s1_byte),
    .text_check_enable (text_check_enable),
    .result            (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      text_check_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      text_check_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_accept || (s1_valid && !advance);
      out_valid <= advance || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte <= in_byte;
    end
    if (advance) begin
      out_reg <= core_result;
    end
  end

  assign out_byte       = out_reg.out_byte;
  assign is_payload     = out_reg.is_payload;
  assign frame_kind     = out_reg.frame_kind;
  assign header_done    = out_reg.header_done;
  assign payload_length = out_reg.payload_length;
  assign frame_end      = out_reg.frame_end;
  assign bad_text       = out_reg.bad_text;
  assign error_flag     = out_reg.error_flag;

endmodule

`default_nettype wire

### src/wsdf_checker.sv
// ----------------------------------------------------------------------------
// WebSocket deframer checker
// Port-level assertions on the deframer result stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "websocket_frame_deframer_unmask_unit_defines.svh"

module wsdf_checker
  import wsdf_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [7:0]       out_byte,
  input wire logic             is_payload,
  input wire logic [1:0]       frame_kind,
  input wire logic             header_done,
  input wire logic [LEN_W-1:0] payload_length,
  input wire logic             frame_end,
  input wire logic             bad_text,
  input wire logic             error_flag
);

  `WSDF_ASSERT_NOW(a_error_kind, clk, rst, out_valid && error_flag, frame_kind == KIND_ERROR, "error beat without error kind")

  `WSDF_ASSERT_NEXT(a_error_sticky, clk, rst, out_valid && !out_stall && error_flag, !out_valid || error_flag, "beat after an error is not an error")

  `WSDF_ASSERT_NOW(a_empty_frame_end, clk, rst, out_valid && header_done, frame_end == (payload_length == '0), "header end and frame end disagree")

  `WSDF_ASSERT_NOW(a_bad_text_ctx, clk, rst, out_valid && bad_text, is_payload && !frame_end && frame_kind == KIND_TEXT, "bad text outside text payload")

  `WSDF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_byte), "stalled beat changed")

endmodule

bind websocket_frame_deframer_unmask_unit wsdf_checker u_wsdf_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_byte       (out_byte),
  .is_payload     (is_payload),
  .frame_kind     (frame_kind),
  .header_done    (header_done),
  .payload_length (payload_length),
  .frame_end      (frame_end),
  .bad_text       (bad_text),
  .error_flag     (error_flag)
);

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebSocket deframer testbench
// Drives a byte stream into the deframer and checks each result beat against
// an in-line frame decoder. A short table covers header encodings, the empty
// frame, masking, the text check and the halt on an unknown opcode. Random
// well-formed frames follow, under both text-check settings. Both ports
// idle and stall at random.
// ----------------------------------------------------------------------------

module tb;
  import wsdf_pkg::*;

  localparam int IDLE_LIMIT    = 4000;
  localparam int ITEMS_PER_SET = 345;
  localparam int SETTLE_CYCLES = 6;
  localparam int PRINT_CAP     = 60;

  typedef struct {
    logic [7:0]   b;
    bit           fixed;
    wsdf_result_t res;
  } dir_row_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_data  = 1'b0;

  logic             in_stall;
  logic             out_valid;
  logic [7:0]       out_byte;
  logic             is_payload;
  logic [1:0]       frame_kind;
  logic             header_done;
  logic [LEN_W-1:0] payload_length;
  logic             frame_end;
  logic             bad_text;
  logic             error_flag;
  logic             cfg_ready;

  // decoder state
  phase_t           st_phase    = PH_FIRST;
  kind_t            st_kind     = KIND_TEXT;
  logic             st_masked   = 1'b0;
  logic [2:0]       st_ext_left = '0;
  logic [31:0]      st_key      = '0;
  logic [1:0]       st_key_idx  = '0;
  logic [LEN_W-1:0] st_len      = '0;
  logic [LEN_W-1:0] st_left     = '0;
  logic             st_halted   = 1'b0;
  logic             st_text_chk = 1'b1;

  wsdf_result_t deframed_q[$];
  wsdf_result_t head_res;
  dir_row_t     dir_rows[$];
  int           n_live;
  int           n_sent      = 0;
  int           n_fail      = 0;
  int           calm_left   = 0;
  int           idle_cycles = 0;

  websocket_frame_deframer_unmask_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .is_payload    (is_payload),
    .frame_kind    (frame_kind),
    .header_done   (header_done),
    .payload_length(payload_length),
    .frame_end     (frame_end),
    .bad_text      (bad_text),
    .error_flag    (error_flag),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void finish_header(inout wsdf_result_t r);
    if (st_masked && st_phase != PH_KEY) begin
      st_phase   = PH_KEY;
      st_key_idx = '0;
      st_key     = '0;
    end else begin
      r.header_done = 1'b1;
      if (st_len == '0) begin
        r.frame_end = 1'b1;
        st_phase    = PH_FIRST;
      end else begin
        st_left  = st_len;
        st_phase = PH_PAYLOAD;
      end
    end
  endfunction

  function automatic wsdf_result_t deframe_byte(input logic [7:0] b);
    wsdf_result_t r;
    logic [7:0]   clear;
    r          = '0;
    r.out_byte = b;
    if (st_halted) begin
      r.frame_kind = KIND_ERROR;
      r.error_flag = 1'b1;
      return r;
    end
    case (st_phase)
      PH_SECOND: begin
        st_masked = b[7];
        st_len    = '0;
        if (b[6:0] == LEN7_EXT16) begin
          st_ext_left = EXT16_LEFT;
          st_phase    = PH_EXTLEN;
        end else if (b[6:0] == LEN7_EXT64) begin
          st_ext_left = EXT64_LEFT;
          st_phase    = PH_EXTLEN;
        end else begin
          st_len = LEN_W'(b[6:0]);
          finish_header(r);
        end
      end
      PH_EXTLEN: begin
        // shift in big-endian; the top bit falls off
        st_len = {st_len[LEN_W-9:0], b};
        if (st_ext_left == '0) finish_header(r);
        else st_ext_left = st_ext_left - 3'd1;
      end
      PH_KEY: begin
        st_key = {st_key[23:0], b};
        if (st_key_idx == KEY_LAST) begin
          st_key_idx = '0;
          finish_header(r);
        end else begin
          st_key_idx = st_key_idx + 2'd1;
        end
      end
      PH_PAYLOAD: begin
        r.is_payload = 1'b1;
        if (st_masked) begin
          clear      = b ^ st_key[8*(3-st_key_idx) +: 8];
          st_key_idx = st_key_idx + 2'd1;
          r.out_byte = clear;
          r.bad_text = st_kind == KIND_TEXT && st_text_chk && st_left > 1 &&
                       (clear < PRINT_LO || clear > PRINT_HI);
        end
        if (st_left <= 1) begin
          st_left     = '0;
          r.frame_end = 1'b1;
          st_phase    = PH_FIRST;
        end else begin
          st_left = st_left - 1;
        end
      end
      default: begin
        st_len  = '0;
        st_left = '0;
        case (b[3:0])
          OP_TEXT:   st_kind = KIND_TEXT;
          OP_BINARY: st_kind = KIND_BINARY;
          OP_CLOSE:  st_kind = KIND_CLOSE;
          default: begin
            st_halted    = 1'b1;
            st_kind      = KIND_ERROR;
            r.frame_kind = KIND_ERROR;
            r.error_flag = 1'b1;
            return r;
          end
        endcase
        st_phase = PH_SECOND;
      end
    endcase
    r.frame_kind     = st_kind;
    r.payload_length = st_len;
    return r;
  endfunction

  function automatic void add_row(input logic [7:0] b);
    dir_row_t row;
    row.b     = b;
    row.fixed = 1'b0;
    row.res   = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_fixed(input logic [7:0] b, input kind_t k,
                                    input logic hd, input logic fe, input logic err);
    dir_row_t row;
    row.b               = b;
    row.fixed           = 1'b1;
    row.res             = '0;
    row.res.out_byte    = b;
    row.res.frame_kind  = k;
    row.res.header_done = hd;
    row.res.frame_end   = fe;
    row.res.error_flag  = err;
    dir_rows.push_back(row);
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left = $urandom_range(20, 100);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    n_fail++;
    if (n_fail <= PRINT_CAP) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [LEN_W-1:0] got,
                             input logic [LEN_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic drive_byte(input logic [7:0] b, input wsdf_result_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    deframed_q.push_back(want);
    in_valid <= 1'b1;
    in_byte  <= b;
    n_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_byte(input logic [7:0] b);
    drive_byte(b, deframe_byte(b));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_text_check(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    st_text_chk  = v;
  endtask

  task automatic send_frame();
    logic [3:0]  op;
    logic        masked;
    logic [31:0] key;
    logic [7:0]  c;
    int          len;
    int          r;
    r      = $urandom_range(0, 99);
    op     = r < 50 ? OP_TEXT : (r < 80 ? OP_BINARY : OP_CLOSE);
    masked = $urandom_range(0, 3) != 0;
    key    = $urandom_range(0, 9) == 0 ? 32'h0 : $urandom;
    send_byte({4'($urandom), op});
    r = $urandom_range(0, 99);
    if (r < 84) begin
      if (r < 10) len = 0;
      else if (r < 70) len = $urandom_range(1, 20);
      else len = $urandom_range(21, 125);
      send_byte({masked, 7'(len)});
    end else if (r < 95) begin
      len = $urandom_range(0, 260);
      send_byte({masked, LEN7_EXT16});
      send_byte(8'(len >> 8));
      send_byte(8'(len));
    end else begin
      len = $urandom_range(0, 40);
      send_byte({masked, LEN7_EXT64});
      send_byte({1'($urandom), 7'd0});
      repeat (5) send_byte(8'h00);
      send_byte(8'(len >> 8));
      send_byte(8'(len));
    end
    if (masked) begin
      for (int i = 0; i < 4; i++) send_byte(key[8*(3-i) +: 8]);
    end
    for (int i = 0; i < len; i++) begin
      if (op == OP_TEXT && $urandom_range(0, 99) < 85) c = 8'($urandom_range(8'h20, 8'h7e));
      else c = 8'($urandom);
      if (masked) c = c ^ key[8*(3-(i%4)) +: 8];
      send_byte(c);
    end
  endtask

  // receiver stall pattern
  initial begin
    int n;
    int r;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 6);
      end else if (r < 85) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 3);
      end else if (r < 95) begin
        out_stall <= 1'b1;
        n = $urandom_range(6, 30);
      end else begin
        out_stall <= 1'b0;
        n = $urandom_range(30, 120);
      end
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (deframed_q.size() == 0) begin
        report_mismatch($sformatf("result beat %02h with nothing pending", out_byte));
      end else begin
        head_res = deframed_q.pop_front();
        check_field("out_byte", out_byte, head_res.out_byte);
        check_field("is_payload", is_payload, head_res.is_payload);
        check_field("frame_kind", frame_kind, head_res.frame_kind);
        check_field("header_done", header_done, head_res.header_done);
        check_field("payload_length", payload_length, head_res.payload_length);
        check_field("frame_end", frame_end, head_res.frame_end);
        check_field("bad_text", bad_text, head_res.bad_text);
        check_field("error_flag", error_flag, head_res.error_flag);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("** websocket_frame_deframer_unmask_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    wsdf_result_t pred;
    add_fixed(8'h81, KIND_TEXT, 1'b0, 1'b0, 1'b0);
    add_fixed(8'h00, KIND_TEXT, 1'b1, 1'b1, 1'b0);
    // masked close, 16-bit length of zero
    add_row(8'hF8); add_row(8'hFE); add_row(8'h00); add_row(8'h00);
    add_row(8'hFF); add_row(8'h00); add_row(8'hA5); add_row(8'h5A);
    // masked text, zero key, control bytes
    add_row(8'h01); add_row(8'h83);
    add_row(8'h00); add_row(8'h00); add_row(8'h00); add_row(8'h00);
    add_row(8'h1F); add_row(8'h7F); add_row(8'h00);
    // binary, 64-bit length with the top bit set
    add_row(8'h82); add_row(8'h7F); add_row(8'h80);
    repeat (6) add_row(8'h00);
    add_row(8'h01); add_row(8'hFF);
    n_live = dir_rows.size();
    // halt rows go last; only reset clears the halt
    add_fixed(8'h8A, KIND_ERROR, 1'b0, 1'b0, 1'b1);
    add_fixed(8'h81, KIND_ERROR, 1'b0, 1'b0, 1'b1);
    add_fixed(8'h00, KIND_ERROR, 1'b0, 1'b0, 1'b1);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < n_live; i++) begin
      pred = deframe_byte(dir_rows[i].b);
      drive_byte(dir_rows[i].b, dir_rows[i].fixed ? dir_rows[i].res : pred);
    end

    for (int s = 0; s < 4; s++) begin
      drain_results();
      write_text_check(s[0]);
      while (n_sent < n_live + (s + 1) * ITEMS_PER_SET) send_frame();
    end
    drain_results();

    for (int i = n_live; i < dir_rows.size(); i++) begin
      pred = deframe_byte(dir_rows[i].b);
      drive_byte(dir_rows[i].b, dir_rows[i].fixed ? dir_rows[i].res : pred);
    end
    repeat (12) send_byte(8'($urandom));
    drain_results();

    if (n_fail == 0) begin
      $display("** websocket_frame_deframer_unmask_unit: PASSED **");
    end else begin
      $display("** websocket_frame_deframer_unmask_unit: FAILED **");
    end
    $finish;
  end

endmodule
